// ===== rtl/sobel_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_pkg: shared types and constants of the Sobel edge magnitude block
// Beat layouts, register indexes, queue sizing and the square root step.
// ----------------------------------------------------------------------------
package sobel_pkg;

  // field widths
  localparam int PIX_W  = 8;
  localparam int COL_W  = 11;
  localparam int ROW_W  = 12;
  localparam int GRAD_W = 11;
  localparam int SQ_W   = 20;

  // configuration port
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 12;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;
  localparam logic [CFG_DATA_W-1:0]  WIDTH_RESET      = 12'd640;
  localparam logic [CFG_DATA_W-1:0]  HEIGHT_RESET     = 12'd480;

  // gradient queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // magnitudes above 254 squared all give an edge value of zero
  localparam logic [SQ_W:0] SAT_LIMIT = 21'd64516;

  // input beat
  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             frame_start;
  } in_t;

  // output beat
  typedef struct packed {
    logic [PIX_W-1:0] edge_value;
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic             frame_last;
  } out_t;

  // position tag carried alongside each gradient
  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
    logic             last;
  } pos_t;

  // queue entry
  typedef struct packed {
    logic signed [GRAD_W-1:0] gx;
    logic signed [GRAD_W-1:0] gy;
    pos_t                     pos;
  } grad_t;

  // partial state of the digit-by-digit square root
  typedef struct packed {
    logic [10:0] rem;
    logic [7:0]  root;
  } sqrt_t;

  // one radix-4 digit of the square root: bring down two bits, try 4r+1
  function automatic sqrt_t sqrt_step(input sqrt_t s, input logic [1:0] pair);
    logic [10:0] rem_sh;
    logic [10:0] trial;
    sqrt_t       res;
    rem_sh = {s.rem[8:0], pair};
    trial  = {1'b0, s.root, 2'b01};
    if (rem_sh >= trial) begin
      res.rem  = rem_sh - trial;
      res.root = {s.root[6:0], 1'b1};
    end else begin
      res.rem  = rem_sh;
      res.root = {s.root[6:0], 1'b0};
    end
    return res;
  endfunction

endpackage

// ===== rtl/sobel_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_queue: short gradient queue
// Four-entry first-in first-out buffer between the window front end and the
// magnitude back end.
// ----------------------------------------------------------------------------
module sobel_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  sobel_pkg::grad_t  push_data,
  input  logic              pop,
  output sobel_pkg::grad_t  head,
  output logic              empty,
  output logic              full
);

  sobel_pkg::grad_t                    slots [sobel_pkg::QUEUE_DEPTH];
  logic [sobel_pkg::QPTR_W-1:0]        wr_ptr;
  logic [sobel_pkg::QPTR_W-1:0]        rd_ptr;
  logic [sobel_pkg::QCNT_W-1:0]        count;

  // status
  assign empty = (count == '0);
  assign full  = (count == sobel_pkg::QCNT_W'(sobel_pkg::QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/sobel_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_front: pixel intake, line store and 3x3 window
// Tracks column and row, keeps the two previous rows, forms the window,
// decides which pixels are interior and pushes their gradients.
// ----------------------------------------------------------------------------
module sobel_front #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                                 pix_valid,
  output logic                                 pix_stall,
  input  sobel_pkg::in_t                       pix_data,
  input  logic                                 q_pop,
  output logic                                 q_push,
  output sobel_pkg::grad_t                     q_data
);

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int EW  = ($clog2(MAX_WIDTH + 1) > sobel_pkg::CFG_DATA_W) ?
                       $clog2(MAX_WIDTH + 1) : sobel_pkg::CFG_DATA_W;
  localparam int PW  = sobel_pkg::PIX_W;
  localparam int RW  = sobel_pkg::ROW_W;
  localparam int GW  = sobel_pkg::GRAD_W;
  localparam int CRW = sobel_pkg::QCNT_W;

  // configuration and position
  logic [sobel_pkg::CFG_DATA_W-1:0] image_width;
  logic [sobel_pkg::CFG_DATA_W-1:0] image_height;
  logic [CW-1:0]                    col;
  logic [RW-1:0]                    row;
  logic [CRW-1:0]                   credits;

  // intake decode
  logic                    accept;
  logic [CW-1:0]           c_cur;
  logic [RW-1:0]           r_cur;
  logic [EW-1:0]           c_ext;
  logic [EW-1:0]           iw_ext;
  logic [EW-1:0]           w_use;
  logic [RW-1:0]           h_use;
  logic                    interior;
  logic                    last_px;
  logic                    row_end;
  logic                    frame_end;
  sobel_pkg::pos_t         pos_cur;

  // line store and stage A
  logic [2*PW-1:0]         line_mem [MAX_WIDTH];
  logic [2*PW-1:0]         rd_data;
  logic                    a_valid;
  logic                    a_res;
  logic [PW-1:0]           a_px;
  logic [CW-1:0]           a_addr;
  sobel_pkg::pos_t         a_pos;
  logic                    lw_valid;
  logic [CW-1:0]           lw_addr;
  logic [2*PW-1:0]         lw_data;
  logic [2*PW-1:0]         fwd_data;
  logic [2*PW-1:0]         wr_data;

  // window and stage B
  logic [PW-1:0]           win [9];
  logic signed [GW-1:0]    ws  [9];
  logic                    b_valid;
  sobel_pkg::pos_t         b_pos;

  // intake: a beat is taken while the queue has a free slot reserved for it
  assign pix_stall = (credits >= CRW'(sobel_pkg::QUEUE_DEPTH));
  assign accept    = pix_valid && !pix_stall;

  // geometry in use and position tests
  always_comb begin
    c_cur     = pix_data.frame_start ? '0 : col;
    r_cur     = pix_data.frame_start ? '0 : row;
    c_ext     = EW'(c_cur);
    iw_ext    = EW'(image_width);
    if (iw_ext < EW'(3)) begin
      w_use = EW'(3);
    end else if (iw_ext > EW'(MAX_WIDTH)) begin
      w_use = EW'(MAX_WIDTH);
    end else begin
      w_use = iw_ext;
    end
    h_use     = (image_height < 12'd3) ? 12'd3 : image_height;
    interior  = (c_ext >= EW'(2)) && (c_ext <= w_use - EW'(1)) &&
                (r_cur >= 12'd2) && (r_cur <= h_use - 12'd1);
    last_px   = (c_ext == w_use - EW'(1)) && (r_cur == h_use - 12'd1);
    row_end   = ((c_ext + EW'(1)) >= w_use);
    frame_end = (({1'b0, r_cur} + 13'd1) >= {1'b0, h_use});
    pos_cur.col  = sobel_pkg::COL_W'(c_ext - EW'(1));
    pos_cur.row  = r_cur - 12'd1;
    pos_cur.last = last_px;
  end

  // configuration, position counters and queue credits
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= sobel_pkg::WIDTH_RESET;
      image_height <= sobel_pkg::HEIGHT_RESET;
      col          <= '0;
      row          <= '0;
      credits      <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          sobel_pkg::REG_IMAGE_WIDTH:  image_width  <= cfg_data;
          sobel_pkg::REG_IMAGE_HEIGHT: image_height <= cfg_data;
        endcase
      end
      if (accept) begin
        if (row_end) begin
          col <= '0;
          row <= frame_end ? '0 : r_cur + 12'd1;
        end else begin
          col <= CW'(c_ext + EW'(1));
          row <= r_cur;
        end
      end
      case ({accept && interior, q_pop})
        2'b10:   credits <= credits + 1'b1;
        2'b01:   credits <= credits - 1'b1;
        default: credits <= credits;
      endcase
    end
  end

  // line store: upper row in the high byte, middle row in the low byte
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[c_cur];
    end
    if (a_valid) begin
      line_mem[a_addr] <= wr_data;
    end
  end

  // bypass the write that landed on the same edge as this beat's read
  assign fwd_data = (lw_valid && (lw_addr == a_addr)) ? lw_data : rd_data;
  assign wr_data  = {fwd_data[PW-1:0], a_px};

  // stage A payload
  always_ff @(posedge clk) begin
    a_px    <= pix_data.pixel;
    a_addr  <= c_cur;
    a_res   <= interior;
    a_pos   <= pos_cur;
    lw_addr <= a_addr;
    lw_data <= wr_data;
    b_pos   <= a_pos;
  end

  // stage control and window shift
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid  <= 1'b0;
      lw_valid <= 1'b0;
      b_valid  <= 1'b0;
      for (int i = 0; i < 9; i++) begin
        win[i] <= '0;
      end
    end else begin
      a_valid  <= accept;
      lw_valid <= a_valid;
      b_valid  <= a_valid && a_res;
      if (a_valid) begin
        for (int i = 0; i < 3; i++) begin
          win[i*3]     <= win[i*3 + 1];
          win[i*3 + 1] <= win[i*3 + 2];
        end
        win[2] <= fwd_data[2*PW-1:PW];
        win[5] <= fwd_data[PW-1:0];
        win[8] <= a_px;
      end
    end
  end

  // Sobel kernels over the settled window
  always_comb begin
    for (int i = 0; i < 9; i++) begin
      ws[i] = signed'({3'b000, win[i]});
    end
    q_data.gx  = (ws[0] - ws[2]) + ((ws[3] - ws[5]) <<< 1) + (ws[6] - ws[8]);
    q_data.gy  = (ws[0] + (ws[1] <<< 1) + ws[2]) - (ws[6] + (ws[7] <<< 1) + ws[8]);
    q_data.pos = b_pos;
  end

  assign q_push = b_valid;

endmodule

// ===== rtl/sobel_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_back: gradient magnitude and edge value
// Squares, sums, takes the ceiling square root in two radix-4 stages and
// holds the finished beat in the output register.
// ----------------------------------------------------------------------------
module sobel_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_empty,
  input  sobel_pkg::grad_t  q_head,
  output logic              q_pop,
  output logic              edge_valid,
  input  logic              edge_stall,
  output sobel_pkg::out_t   edge_data
);

  localparam int SW = sobel_pkg::SQ_W;

  logic                        adv;
  logic signed [2*sobel_pkg::GRAD_W-1:0] prod_x;
  logic signed [2*sobel_pkg::GRAD_W-1:0] prod_y;

  // stage 1: squares
  logic                        s1_valid;
  logic [SW-1:0]               s1_sqx;
  logic [SW-1:0]               s1_sqy;
  sobel_pkg::pos_t             s1_pos;

  // stage 2: sum of squares
  logic [SW:0]                 sum;
  logic                        s2_valid;
  logic                        s2_big;
  logic [15:0]                 s2_n;
  sobel_pkg::pos_t             s2_pos;

  // stage 3: upper four root digits
  sobel_pkg::sqrt_t            hi_sq;
  logic                        s3_valid;
  logic                        s3_big;
  sobel_pkg::sqrt_t            s3_sq;
  logic [7:0]                  s3_low;
  sobel_pkg::pos_t             s3_pos;

  // output: lower four digits, ceiling and edge value
  sobel_pkg::sqrt_t            lo_sq;
  logic [8:0]                  mag;
  logic [sobel_pkg::PIX_W-1:0] edge_val;

  // whole back end moves unless a finished beat is held up
  assign adv    = !(edge_valid && edge_stall);
  assign q_pop  = adv && !q_empty;
  assign prod_x = q_head.gx * q_head.gx;
  assign prod_y = q_head.gy * q_head.gy;
  assign sum    = {1'b0, s1_sqx} + {1'b0, s1_sqy};

  // digit recurrence, four digits per stage
  always_comb begin
    hi_sq = '0;
    for (int i = 3; i >= 0; i--) begin
      hi_sq = sobel_pkg::sqrt_step(hi_sq, s2_n[8 + 2*i +: 2]);
    end
    lo_sq = s3_sq;
    for (int i = 3; i >= 0; i--) begin
      lo_sq = sobel_pkg::sqrt_step(lo_sq, s3_low[2*i +: 2]);
    end
    mag = {1'b0, lo_sq.root} + {8'd0, (lo_sq.rem != '0)};
    if (s3_big || (mag >= 9'd255)) begin
      edge_val = '0;
    end else begin
      edge_val = sobel_pkg::PIX_W'(9'd255 - mag);
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_sqx    <= prod_x[SW-1:0];
      s1_sqy    <= prod_y[SW-1:0];
      s1_pos    <= q_head.pos;
      s2_big    <= (sum > sobel_pkg::SAT_LIMIT);
      s2_n      <= sum[15:0];
      s2_pos    <= s1_pos;
      s3_big    <= s2_big;
      s3_sq     <= hi_sq;
      s3_low    <= s2_n[7:0];
      s3_pos    <= s2_pos;
      edge_data.edge_value <= edge_val;
      edge_data.out_col    <= s3_pos.col;
      edge_data.out_row    <= s3_pos.row;
      edge_data.frame_last <= s3_pos.last;
    end
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s2_valid   <= 1'b0;
      s3_valid   <= 1'b0;
      edge_valid <= 1'b0;
    end else if (adv) begin
      s1_valid   <= q_pop;
      s2_valid   <= s1_valid;
      s3_valid   <= s2_valid;
      edge_valid <= s3_valid;
    end
  end

endmodule

// ===== rtl/sobel_edge_magnitude.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude: streaming 3x3 Sobel edge detector
// Raster pixels in, 255 minus the rounded-up gradient magnitude out for
// every interior pixel, tagged with its column, row and end of frame.
// ----------------------------------------------------------------------------
// Usage
//   pix_valid / pix_stall / pix_data carry one grayscale pixel per beat in
//   raster order; frame_start on a beat restarts counting at column 0, row 0.
//   edge_valid / edge_stall / edge_data carry one result per interior pixel;
//   border pixels give no beat. cfg_we writes image_width (index 0) or
//   image_height (index 1) from cfg_data; the user must write them only
//   while the block is idle, which the block does not enforce. Throughput
//   is one pixel per clock while pix_stall is low. A result goes from the
//   pixel that completes its window through line store read and window,
//   queue, squares, sum, two radix-4 root stages and output register.
//   pix_stall rises once four interior results are held between intake and
//   the back end's first stage; a stalled output freezes the back end while
//   the front keeps taking pixels until the queue is spoken for.
//   Reset sets 640 x 480, clears position, window and pipeline; line store
//   contents are left as they are and are rewritten by the first two rows.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              pix_valid,
  output logic                              pix_stall,
  input  sobel_pkg::in_t                    pix_data,
  output logic                              edge_valid,
  input  logic                              edge_stall,
  output sobel_pkg::out_t                   edge_data
);

  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              q_full;
  sobel_pkg::grad_t  q_in;
  sobel_pkg::grad_t  q_head;

  // window front end
  sobel_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pix_valid (pix_valid),
    .pix_stall (pix_stall),
    .pix_data  (pix_data),
    .q_pop     (q_pop),
    .q_push    (q_push),
    .q_data    (q_in)
  );

  // gradient queue
  sobel_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .empty     (q_empty),
    .full      (q_full)
  );

  // magnitude back end
  sobel_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .edge_data  (edge_data)
  );

`ifndef SYNTH
  // credits must keep the queue from ever being pushed while full
  a_queue_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("gradient queue pushed while full");

  // nothing leaves the block on the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !edge_valid)
    else $error("result beat shown right after reset");
`endif

endmodule

// ===== sim/sobel_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_checker: result predictor and scoreboard for the Sobel edge block
// Follows configuration writes and accepted pixel beats with its own line
// stores, window and position counters. Each interior pixel queues the
// expected edge beat, and every accepted edge beat is compared field by
// field against the oldest entry.
// ----------------------------------------------------------------------------
module sobel_checker #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                              pix_valid,
  input  logic                              pix_stall,
  input  sobel_pkg::in_t                    pix_data,
  input  logic                              edge_valid,
  input  logic                              edge_stall,
  input  sobel_pkg::out_t                   edge_data,
  output int                                errors,
  output int                                pending
);

  // shadow of the geometry registers
  logic [sobel_pkg::CFG_DATA_W-1:0] width_reg;
  logic [sobel_pkg::CFG_DATA_W-1:0] height_reg;

  // rows r-2 and r-1 of the incoming stream, indexed by column
  logic [sobel_pkg::PIX_W-1:0] two_rows_up [MAX_WIDTH];
  logic [sobel_pkg::PIX_W-1:0] one_row_up  [MAX_WIDTH];

  // 3x3 neighbourhood, [row][col], row 0 at the top, col 0 on the left
  logic [sobel_pkg::PIX_W-1:0] win [3][3];

  int unsigned     col_pos;
  int unsigned     row_pos;
  sobel_pkg::out_t expected_edges [$];
  int              fail_count = 0;

  assign errors = fail_count;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: %s", $time, msg);
    fail_count++;
  endtask

  // smallest r with r*r >= sq
  function automatic int unsigned root_up(input int unsigned sq);
    int unsigned r;
    r = $rtoi($sqrt(sq));
    while (r * r < sq) r++;
    while (r > 0 && (r - 1) * (r - 1) >= sq) r--;
    return r;
  endfunction

  // advance the stream model by one pixel beat
  task automatic take_pixel(input sobel_pkg::in_t beat);
    int unsigned                 w, h, c, r, mag;
    int                          gx, gy, i;
    logic [sobel_pkg::PIX_W-1:0] above2, above1;
    sobel_pkg::out_t             res;
    w = width_reg;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    h = height_reg;
    if (h < 3) h = 3;
    if (beat.frame_start) begin
      col_pos = 0;
      row_pos = 0;
    end
    c = col_pos;
    r = row_pos;

    // line store read and rotate
    if (c < MAX_WIDTH) begin
      above2         = two_rows_up[c];
      above1         = one_row_up[c];
      two_rows_up[c] = above1;
      one_row_up[c]  = beat.pixel;
    end else begin
      above2 = '0;
      above1 = '0;
    end

    // shift the window left, new column enters on the right
    for (i = 0; i < 3; i++) begin
      win[i][0] = win[i][1];
      win[i][1] = win[i][2];
    end
    win[0][2] = above2;
    win[1][2] = above1;
    win[2][2] = beat.pixel;

    // interior centre: both kernels and the saturated magnitude
    if (c >= 2 && c <= w - 1 && r >= 2 && r <= h - 1) begin
      gx = (int'(win[0][0]) - int'(win[0][2])) + 2 * (int'(win[1][0]) - int'(win[1][2]))
         + (int'(win[2][0]) - int'(win[2][2]));
      gy = (int'(win[0][0]) + 2 * int'(win[0][1]) + int'(win[0][2]))
         - (int'(win[2][0]) + 2 * int'(win[2][1]) + int'(win[2][2]));
      mag = root_up(gx * gx + gy * gy);
      res.edge_value = (mag >= 255) ? '0 : sobel_pkg::PIX_W'(255 - mag);
      res.out_col    = sobel_pkg::COL_W'(c - 1);
      res.out_row    = sobel_pkg::ROW_W'(r - 1);
      res.frame_last = (c == w - 1) && (r == h - 1);
      expected_edges.push_back(res);
    end

    // position counters
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // compare one edge beat with the oldest expectation
  task automatic check_edge(input sobel_pkg::out_t got);
    sobel_pkg::out_t want;
    if (expected_edges.size() == 0) begin
      report_mismatch($sformatf("edge beat with nothing expected: value %0d at (%0d,%0d)",
                                got.edge_value, got.out_col, got.out_row));
    end else begin
      want = expected_edges.pop_front();
      if (got.edge_value !== want.edge_value)
        report_mismatch($sformatf("edge_value at (%0d,%0d): got %0d, expected %0d",
                                  want.out_col, want.out_row, got.edge_value, want.edge_value));
      if (got.out_col !== want.out_col)
        report_mismatch($sformatf("out_col: got %0d, expected %0d", got.out_col, want.out_col));
      if (got.out_row !== want.out_row)
        report_mismatch($sformatf("out_row: got %0d, expected %0d", got.out_row, want.out_row));
      if (got.frame_last !== want.frame_last)
        report_mismatch($sformatf("frame_last at (%0d,%0d): got %0b, expected %0b",
                                  want.out_col, want.out_row, got.frame_last, want.frame_last));
    end
  endtask

  // watch both channels and the register port
  always @(posedge clk) begin
    int i;
    if (rst) begin
      width_reg  = sobel_pkg::WIDTH_RESET;
      height_reg = sobel_pkg::HEIGHT_RESET;
      col_pos    = 0;
      row_pos    = 0;
      for (i = 0; i < 9; i++) win[i / 3][i % 3] = '0;
      expected_edges.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sobel_pkg::REG_IMAGE_WIDTH:  width_reg  = cfg_data;
          sobel_pkg::REG_IMAGE_HEIGHT: height_reg = cfg_data;
          default: ;
        endcase
      end
      if (pix_valid && !pix_stall) take_pixel(pix_data);
      if (edge_valid && !edge_stall) check_edge(edge_data);
    end
    pending = expected_edges.size();
  end

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: stimulus and verdict for the Sobel edge magnitude block
// Drives a short directed set of 3x3 frames, then random geometries and
// textures with random idling on both sides, a long output hold-off and
// the tallest height. Checking is left to sobel_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_WIDTH    = 2048;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 150;
  localparam int CYCLE_LIMIT  = 500000;

  typedef enum int { TEX_NOISE, TEX_BINARY, TEX_SOFT, TEX_FLAT } texture_t;

  logic                              clk       = 1'b0;
  logic                              rst       = 1'b1;
  logic                              cfg_we    = 1'b0;
  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index = sobel_pkg::REG_IMAGE_WIDTH;
  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data  = '0;
  logic                              pix_valid = 1'b0;
  logic                              pix_stall;
  sobel_pkg::in_t                    pix_data  = '0;
  logic                              edge_valid;
  logic                              edge_stall = 1'b0;
  sobel_pkg::out_t                   edge_data;
  int                                errors;
  int                                pending;

  int cycles       = 0;
  int random_items = 0;
  int tx_spell     = 0;
  bit tx_busy      = 1'b1;
  int rx_spell     = 0;
  bit rx_busy      = 1'b1;
  int rx_wait      = 0;
  bit rx_took      = 1'b0;
  bit hold_off     = 1'b0;
  bit pressure_go  = 1'b0;

  sobel_edge_magnitude #(.MAX_WIDTH(MAX_WIDTH)) i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .edge_data  (edge_data)
  );

  sobel_checker #(.MAX_WIDTH(MAX_WIDTH)) i_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .pix_valid  (pix_valid),
    .pix_stall  (pix_stall),
    .pix_data   (pix_data),
    .edge_valid (edge_valid),
    .edge_stall (edge_stall),
    .edge_data  (edge_data),
    .errors     (errors),
    .pending    (pending)
  );

  // 50 MHz clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // result side: note each accepted beat for the stall driver
  always @(posedge clk) begin
    rx_took <= edge_valid && !edge_stall;
  end

  // result side: a random stall after each beat, in busy and quiet spells
  always @(negedge clk) begin
    if (rx_took) begin
      if (rx_spell == 0) begin
        rx_spell = $urandom_range(20, 80);
        rx_busy  = $urandom_range(0, 3) != 0;
      end
      rx_spell--;
      rx_wait = rx_busy ? $urandom_range(0, 3) : 0;
    end
    if (hold_off) begin
      edge_stall <= 1'b1;
    end else if (rx_wait > 0) begin
      edge_stall <= 1'b1;
      rx_wait--;
    end else begin
      edge_stall <= 1'b0;
    end
  end

  // long output hold-off so the block fills and stalls its input
  initial begin
    wait (pressure_go);
    @(posedge clk);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off = 1'b0;
  end

  // one pixel beat, preceded by a random gap; called and returns at a falling edge
  task automatic send_pixel(input logic [sobel_pkg::PIX_W-1:0] value, input logic restart);
    int gap;
    if (tx_spell == 0) begin
      tx_spell = $urandom_range(20, 80);
      tx_busy  = $urandom_range(0, 3) != 0;
    end
    tx_spell--;
    gap = tx_busy ? $urandom_range(0, 3) : 0;
    if (gap > 0) begin
      pix_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pix_valid <= 1'b1;
    pix_data  <= sobel_pkg::in_t'{pixel: value, frame_start: restart};
    @(posedge clk);
    while (pix_stall) @(posedge clk);
    random_items++;
    @(negedge clk);
  endtask

  // a run of pixels with one texture; stray frame starts now and then
  task automatic send_run(input int count, input logic restart);
    texture_t                    tex;
    int                          spread, base, k;
    logic [sobel_pkg::PIX_W-1:0] value;
    logic                        fs;
    tex    = texture_t'($urandom_range(0, 3));
    spread = $urandom_range(4, 80);
    base   = $urandom_range(0, 255 - spread);
    for (k = 0; k < count; k++) begin
      case (tex)
        TEX_NOISE:  value = sobel_pkg::PIX_W'($urandom_range(0, 255));
        TEX_BINARY: value = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        TEX_SOFT:   value = sobel_pkg::PIX_W'(base + $urandom_range(0, spread));
        default:    value = sobel_pkg::PIX_W'(base);
      endcase
      fs = (k == 0) ? restart : ($urandom_range(0, 149) == 0);
      send_pixel(value, fs);
    end
  endtask

  // wait for every expected beat plus the pipeline depth
  task automatic settle();
    pix_valid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // both geometry registers, write enable held across the two beats
  task automatic set_geometry(input logic [sobel_pkg::CFG_DATA_W-1:0] w,
                              input logic [sobel_pkg::CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= sobel_pkg::REG_IMAGE_WIDTH;
    cfg_data  <= w;
    @(negedge clk);
    cfg_index <= sobel_pkg::REG_IMAGE_HEIGHT;
    cfg_data  <= h;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  initial begin
    int f, k, phase, gw, gh, ew, eh, frames;
    logic [sobel_pkg::PIX_W-1:0] v;

    // reset
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    settle();

    // directed 3x3 frames: strong vertical edge, faint corner (ceiling
    // rounding), frame following by row wrap, faint horizontal edge
    set_geometry(12'd0, 12'd0);
    for (f = 0; f < 3; f++) begin
      for (k = 0; k < 9; k++) begin
        case (f)
          0:       v = (k % 3 == 0) ? 8'hFF : 8'h00;
          1:       v = (k == 0) ? 8'd3 : 8'd0;
          default: v = (k < 3) ? 8'd10 : 8'd0;
        endcase
        send_pixel(v, (k == 0) && (f != 1));
      end
    end
    random_items = 0;

    // random geometries; the first one carries the long hold-off
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (phase == 0) begin
        gw = 4;
        gh = 40;
      end else begin
        gw = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 90) : $urandom_range(0, 14);
        gh = $urandom_range(0, 10);
      end
      ew = (gw < 3) ? 3 : gw;
      eh = (gh < 3) ? 3 : gh;
      settle();
      set_geometry(sobel_pkg::CFG_DATA_W'(gw), sobel_pkg::CFG_DATA_W'(gh));
      if (phase == 0) begin
        pressure_go = 1'b1;
        send_run(ew * eh, 1'b1);
      end else begin
        frames = $urandom_range(1, 3);
        for (f = 0; f < frames; f++) begin
          if ($urandom_range(0, 5) == 0)
            send_run($urandom_range(1, ew * eh), 1'b1);
          else
            send_run(ew * eh, (f == 0) || $urandom_range(0, 1));
        end
      end
      phase++;
    end

    // tallest frame, only its first rows
    settle();
    set_geometry(12'd5, 12'd4095);
    send_run(5 * 6, 1'b1);

    settle();
    if (errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
